FILE: hw/rtl/base64_stream_encoder_defines.svh
// Assertion helpers for the encoder checker.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define B64E_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

    localparam int LIMIT_W      = 16;
    localparam int BYTE_W       = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [7:0]         PAD_CHAR    = 8'h3D;
    localparam logic [7:0]         PLUS_CHAR   = 8'h2B;
    localparam logic [7:0]         SLASH_CHAR  = 8'h2F;
    localparam logic [5:0]         SIX_MASK    = 6'h3F;

    // Number of real bytes in a group
    localparam logic [1:0] NB_ONE   = 2'd1;
    localparam logic [1:0] NB_TWO   = 2'd2;
    localparam logic [1:0] NB_THREE = 2'd3;

    // Group phase codes
    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;
    localparam logic [1:0] PH_BAD   = 2'd3;

    // One group request from front to back
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [1:0] nbytes;
    } group_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Map a sextet to its character in the standard alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [5:0] m;
        logic [7:0] r;
        m = v & SIX_MASK;
        if (m < 6'd26) begin
            r = 8'h41 + {2'b00, m};
        end else if (m < 6'd52) begin
            r = 8'h61 + {2'b00, m - 6'd26};
        end else if (m < 6'd62) begin
            r = 8'h30 + {2'b00, m - 6'd52};
        end else if (m == 6'd62) begin
            r = PLUS_CHAR;
        end else begin
            r = SLASH_CHAR;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/base64_stream_encoder.sv
// A closing byte's group is written into the group queue, then loaded into the output
// group register once that is free; the first character is driven from there.
// Throughput: one byte per cycle while the 4-entry group queue has room; the output side
// sends four characters per group. Reset (aresetn low, synchronous): clears phase, group
// count, queue and output valid; group_limit returns to 65535.
`default_nettype none
module base64_stream_encoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,   // group_limit
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,       // [7:0] data_byte
    input  wire         s_tlast,       // last_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,       // [7:0] out_char
    output logic        m_tlast        // last_char
);

    logic [b64e_pkg::LIMIT_W-1:0] limit_reg;
    b64e_pkg::qstat_t             q_stat;
    b64e_pkg::group_t             push_data, pop_data;
    logic                         q_push, q_pop;

    // Hold the group limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= b64e_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    b64e_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .group_limit (limit_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    b64e_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    b64e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/b64e_front.sv
`default_nettype none
module b64e_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire [b64e_pkg::LIMIT_W-1:0]  group_limit,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [7:0]                    s_tdata,
    input  wire                          s_tlast,
    input  b64e_pkg::qstat_t             q_stat,
    output logic                         q_push,
    output b64e_pkg::group_t             q_data
);

    localparam int CMP_W = (COUNT_WIDTH > b64e_pkg::LIMIT_W) ? COUNT_WIDTH
                                                            : b64e_pkg::LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [15:0]            pending_reg, pending_next;
    logic [1:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]             phase_eff;
    logic                   accept;
    logic                   group_done;
    logic                   below_cap;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Treat the unused phase code as empty
    assign phase_eff  = (phase_reg == b64e_pkg::PH_BAD) ? b64e_pkg::PH_EMPTY : phase_reg;
    assign group_done = s_tlast || (phase_eff == b64e_pkg::PH_TWO);
    assign below_cap  = CMP_W'(count_reg) < CMP_W'(group_limit);
    assign q_push     = accept && group_done && below_cap;

    // Build the group request from held bytes and the new byte
    always_comb begin
        q_data = '0;
        case (phase_eff)
            b64e_pkg::PH_ONE: begin
                q_data.a      = pending_reg[15:8];
                q_data.b      = s_tdata;
                q_data.nbytes = b64e_pkg::NB_TWO;
            end
            b64e_pkg::PH_TWO: begin
                q_data.a      = pending_reg[15:8];
                q_data.b      = pending_reg[7:0];
                q_data.c      = s_tdata;
                q_data.nbytes = b64e_pkg::NB_THREE;
            end
            default: begin
                q_data.a      = s_tdata;
                q_data.nbytes = b64e_pkg::NB_ONE;
            end
        endcase
    end

    // Advance phase, held bytes and group count
    always_comb begin
        pending_next = pending_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        if (accept) begin
            if (group_done) begin
                phase_next = b64e_pkg::PH_EMPTY;
            end else if (phase_eff == b64e_pkg::PH_ONE) begin
                pending_next[7:0] = s_tdata;
                phase_next        = b64e_pkg::PH_TWO;
            end else begin
                pending_next = {s_tdata, 8'h00};
                phase_next   = b64e_pkg::PH_ONE;
            end
            if (s_tlast) begin
                count_next = '0;
            end else if (q_push && (count_reg != COUNT_MAX)) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64e_pkg::PH_EMPTY;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Held bytes are read only once a phase says they are valid
    always_ff @(posedge aclk) begin
        pending_reg <= pending_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/b64e_queue.sv
`default_nettype none
module b64e_queue (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  b64e_pkg::group_t  push_data,
    input  wire               pop,
    output b64e_pkg::group_t  pop_data,
    output b64e_pkg::qstat_t  stat
);

    localparam int AW    = b64e_pkg::QUEUE_AW;
    localparam int DEPTH = b64e_pkg::QUEUE_DEPTH;

    b64e_pkg::group_t entries_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = entries_reg[rd_ptr_reg];

    // Store requests at the write pointer
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/b64e_back.sv
`default_nettype none
module b64e_back (
    input  wire               aclk,
    input  wire               aresetn,
    input  b64e_pkg::qstat_t  q_stat,
    input  b64e_pkg::group_t  q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    b64e_pkg::group_t grp_reg;
    logic             valid_reg, valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_done;
    logic             group_end;

    assign out_done  = valid_reg && m_tready;
    assign group_end = out_done && (idx_reg == 2'd3);
    assign q_pop     = (!valid_reg || group_end) && !q_stat.empty;

    assign m_tvalid = valid_reg;
    assign m_tlast  = (idx_reg == 2'd3);

    // Select the character for the current slot
    always_comb begin
        case (idx_reg)
            2'd0: m_tdata = b64e_pkg::sextet_char(grp_reg.a[7:2]);
            2'd1: m_tdata = b64e_pkg::sextet_char({grp_reg.a[1:0], grp_reg.b[7:4]});
            2'd2: m_tdata = (grp_reg.nbytes == b64e_pkg::NB_ONE) ? b64e_pkg::PAD_CHAR
                          : b64e_pkg::sextet_char({grp_reg.b[3:0], grp_reg.c[7:6]});
            default: m_tdata = (grp_reg.nbytes == b64e_pkg::NB_THREE)
                             ? b64e_pkg::sextet_char(grp_reg.c[5:0]) : b64e_pkg::PAD_CHAR;
        endcase
    end

    // Step through the four slots, reload from the queue when idle or at group end
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (q_pop) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (group_end) begin
            valid_next = 1'b0;
            idx_next   = 2'd0;
        end else if (out_done) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            grp_reg <= q_data;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/b64e_checker.sv
`default_nettype none
`include "base64_stream_encoder_defines.svh"
module b64e_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast
);

    logic m_done;
    logic is_pad;
    logic is_alpha;

    assign m_done   = m_tvalid && m_tready;
    assign is_pad   = (m_tdata == b64e_pkg::PAD_CHAR);
    assign is_alpha = (m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                      (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                      (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                      (m_tdata == b64e_pkg::PLUS_CHAR) || (m_tdata == b64e_pkg::SLASH_CHAR);

    // Stalled result keeps its request
    `B64E_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    // Characters of one group follow without a gap
    `B64E_ASSERT_NEXT(a_group_contig, m_done && !m_tlast, m_tvalid, "gap inside a group")
    // Padding runs to the end of the group
    `B64E_ASSERT_NEXT(a_pad_tail, m_done && is_pad && !m_tlast, m_tvalid && is_pad, "data after padding")
    // Only alphabet characters or padding leave the block
    `B64E_ASSERT_NOW(a_charset, m_tvalid, is_alpha || is_pad, "character outside alphabet")
    // The first two slots never carry padding, so padding is never followed by a group end
    // too early: a padded slot is always the third or fourth
    `B64E_ASSERT_NEXT(a_pad_not_first, m_done && m_tlast, !(m_tvalid && is_pad), "group opens with padding")

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: tb/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 100_000;
    localparam int          SUBPHASE_BYTES = 30;

    localparam logic [7:0]  CHAR_UPPER_A = "A";
    localparam logic [7:0]  CHAR_LOWER_A = "a";
    localparam logic [7:0]  CHAR_ZERO    = "0";
    localparam logic [15:0] GROUP_SAT    = 16'hFFFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } b64_char_t;

    // Predicts the character stream and checks the encoder's output against it
    class encoder_scoreboard;
        logic [15:0]  group_limit;
        logic [7:0]   held_a;
        logic [7:0]   held_b;
        logic [1:0]   phase;
        logic [15:0]  groups_done;
        b64_char_t    chars_due[$];
        int unsigned  errors;

        function new();
            group_limit = b64e_pkg::LIMIT_RESET;
            errors      = 0;
            end_message();
        endfunction

        function void end_message();
            held_a      = '0;
            held_b      = '0;
            phase       = b64e_pkg::PH_EMPTY;
            groups_done = '0;
        endfunction

        function logic [7:0] alphabet_char(input logic [5:0] v);
            if (v < 6'd26) return CHAR_UPPER_A + 8'(v);
            if (v < 6'd52) return CHAR_LOWER_A + 8'(v - 6'd26);
            if (v < 6'd62) return CHAR_ZERO + 8'(v - 6'd52);
            return (v == 6'd62) ? b64e_pkg::PLUS_CHAR : b64e_pkg::SLASH_CHAR;
        endfunction

        // Queue four characters for one group unless the cap has been hit
        function void emit_group(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c, input logic [1:0] nreal);
            logic [23:0] bits;
            b64_char_t   g [4];
            if (groups_done >= group_limit) return;
            bits = {a, b, c};
            g[0] = '{alphabet_char(bits[23:18]), 1'b0};
            g[1] = '{alphabet_char(bits[17:12]), 1'b0};
            g[2] = '{(nreal >= b64e_pkg::NB_TWO) ? alphabet_char(bits[11:6])
                                                 : b64e_pkg::PAD_CHAR, 1'b0};
            g[3] = '{(nreal == b64e_pkg::NB_THREE) ? alphabet_char(bits[5:0])
                                                   : b64e_pkg::PAD_CHAR, 1'b1};
            foreach (g[k]) chars_due.push_back(g[k]);
            if (groups_done != GROUP_SAT) groups_done++;
        endfunction

        function void note_request(input logic [7:0] data, input logic last);
            case (phase)
                b64e_pkg::PH_ONE: begin
                    if (last) begin
                        emit_group(held_a, data, 8'h00, b64e_pkg::NB_TWO);
                        end_message();
                    end else begin
                        held_b = data;
                        phase  = b64e_pkg::PH_TWO;
                    end
                end
                b64e_pkg::PH_TWO: begin
                    emit_group(held_a, held_b, data, b64e_pkg::NB_THREE);
                    held_a = '0;
                    held_b = '0;
                    phase  = b64e_pkg::PH_EMPTY;
                    if (last) end_message();
                end
                default: begin
                    // empty phase; the unused code behaves the same way
                    if (last) begin
                        emit_group(data, 8'h00, 8'h00, b64e_pkg::NB_ONE);
                        end_message();
                    end else begin
                        held_a = data;
                        phase  = b64e_pkg::PH_ONE;
                    end
                end
            endcase
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            b64_char_t due;
            if (chars_due.size() == 0) begin
                $error("unexpected character: out_char %h last_char %b", ch, last);
                errors++;
                return;
            end
            due = chars_due.pop_front();
            if (ch !== due.ch) begin
                $error("out_char mismatch: expected %h, actual %h", due.ch, ch);
                errors++;
            end
            if (last !== due.last) begin
                $error("last_char mismatch: expected %b, actual %b", due.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return chars_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] data_byte
    logic        s_tlast;      // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;      // [7:0] out_char
    logic        m_tlast;      // last_char

    encoder_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request  = 1'b0;
    int unsigned cycle_count   = 0;

    base64_stream_encoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check every accepted character
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
    end

    // Drive the receiver: random stalls, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one byte, idle at random first; starts and ends at a falling edge
    task automatic send_request(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(data, last);
        @(negedge aclk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_request(8'($urandom), i == len - 1);
    endtask

    // Drain all results, let the block settle, then write the group limit
    task automatic write_limit(input logic [15:0] value);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.group_limit = value;
    endtask

    initial begin
        int          sent;
        int          len;
        logic [15:0] limit_pick;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: full groups, one and two byte tails, alphabet extremes, reset limit
        send_request("M", 1'b0); send_request("a", 1'b0); send_request("n", 1'b1);
        send_request("M", 1'b0); send_request("a", 1'b1);
        send_request("M", 1'b1);
        send_request(8'h00, 1'b0); send_request(8'h00, 1'b0); send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0); send_request(8'hFF, 1'b0); send_request(8'hFF, 1'b1);
        send_request(8'hFB, 1'b0); send_request(8'hEF, 1'b0); send_request(8'hBE, 1'b1);
        send_request(8'hFF, 1'b1);
        send_request(8'h01, 1'b0); send_request(8'h02, 1'b0);
        send_request(8'h03, 1'b0); send_request(8'h04, 1'b1);

        // Random messages over three idle mixes and several group limits
        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin send_idle_pct = 31; recv_idle_pct = 70; end
                1: begin send_idle_pct = 70; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int sp = 0; sp < 4; sp++) begin
                case ((seg * 4 + sp) % 6)
                    0: limit_pick = 16'd0;
                    1: limit_pick = 16'd1;
                    2: limit_pick = 16'd2;
                    3: limit_pick = 16'hFFFF;
                    4: limit_pick = 16'($urandom_range(3, 8));
                    default: limit_pick = 16'($urandom);
                endcase
                write_limit(limit_pick);
                sent = 0;
                while (sent < SUBPHASE_BYTES) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(12, 30)
                                                   : $urandom_range(1, 9);
                    send_message(len);
                    sent += len;
                end
            end
        end

        // Hold off the receiver while the sender keeps offering
        write_limit(16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 20;
        hold_request  = 1'b1;
        send_message(48);

        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (sb.pending() != 0) $error("%0d characters never arrived", sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
